// ----- sv/bfe_pkg.sv -----
// Shared types, constants and the divisor reciprocal table of the 3x3 box filter.
`default_nettype none

package bfe_pkg;

    localparam int PIX_W          = 8;
    localparam int CFG_WIDTH_W    = 11;
    localparam int CFG_HEIGHT_W   = 13;
    localparam int CFG_DATA_W     = 13;
    localparam int CFG_IDX_W      = 1;
    localparam int ROW_OUT_W      = 12;
    localparam int COL_OUT_W      = 10;
    localparam int OUT_TDATA_W    = 32;
    localparam int OUT_PAD_W      = OUT_TDATA_W - PIX_W - ROW_OUT_W - COL_OUT_W;
    localparam int SUM_W          = 12;
    localparam int RECIP_W        = 17;
    localparam int RECIP_SHIFT    = 16;
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 4096;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } t_cfg_index;

    // One column of the window: lane 0 current row, lane 1 row above, lane 2 two rows above.
    typedef logic [3*PIX_W-1:0] t_column;
    typedef t_column [2:0] t_window;

    typedef struct packed {
        logic [2:0] col_en;
        logic [2:0] lane_en;
    } t_mean_sel;

    // Rounded-up reciprocal of the pixel count, scaled by 2^16. With sums below 2^12 the
    // truncated product equals the floored quotient for every count that can occur.
    function automatic logic [RECIP_W-1:0] f_recip(input logic [1:0] ncols,
                                                   input logic [1:0] nlanes);
        logic [3:0] count;
        logic [RECIP_W-1:0] r;
        count = 4'(ncols) * 4'(nlanes);
        case (count)
            4'd2:    r = 17'd32768;
            4'd3:    r = 17'd21846;
            4'd4:    r = 17'd16384;
            4'd6:    r = 17'd10923;
            4'd9:    r = 17'd7282;
            default: r = 17'd65536;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- sv/box_filter_3x3_edge_average.sv -----
// Pixel input takes one transfer when idle. Each accepted pixel passes a registered line store
// read and a read-modify-write with window shift; then the single shared mean unit serves each
// result it releases with a sum and a multiply; the load into the output register waits while
// that register holds an untaken result. Input is held off until the last result is loaded. A
// finished result sits in the output register, and the next pixel is taken while it waits. Line
// stores are not cleared after reset: entries read before being written only touch neighbours
// outside the frame. Any configuration write restarts the frame at row 0, column 0; widths of
// zero count as one and sizes above the maximum count as the maximum.
`default_nettype none

module box_filter_3x3_edge_average
    import bfe_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [PIX_W-1:0]       s_axis_tdata,    // pixel
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic      [OUT_TDATA_W-1:0] m_axis_tdata,    // smoothed, out_row, out_col, zero pad
    output logic                        m_axis_tlast,    // last_of_run
    output logic                        m_axis_tuser     // end_of_frame
);

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_READ = 5'b00010,
        ST_SUM  = 5'b00100,
        ST_MUL  = 5'b01000,
        ST_LOAD = 5'b10000
    } t_state;

    t_state r_state, n_state;

    logic [CFG_WIDTH_W-1:0]  r_cfg_width;
    logic [CFG_HEIGHT_W-1:0] r_cfg_height;
    logic [CW-1:0]           r_col;
    logic [RW-1:0]           r_row;
    logic [CW-1:0]           r_j;
    logic [RW-1:0]           r_i;
    logic [PIX_W-1:0]        r_pix;
    t_window                 r_window;
    logic [3:0]              r_todo;
    logic [1:0]              r_k;
    logic                    r_out_valid;
    logic [PIX_W-1:0]        r_out_mean;
    logic [ROW_OUT_W-1:0]    r_out_row;
    logic [COL_OUT_W-1:0]    r_out_col;
    logic                    r_out_last;
    logic                    r_out_eof;

    logic [31:0]        w_eff, h_eff;
    logic [CW-1:0]      w_m1;
    logic [RW-1:0]      h_m1;
    logic               in_xfer;
    logic               out_free;
    logic [2*PIX_W-1:0] rd_data;
    logic [1:0]         k_next;
    logic [3:0]         todo_left;
    t_mean_sel          sel;
    logic [PIX_W-1:0]   mean;
    logic               col_last, row_last;

    // Effective frame size, held as size minus one.
    always_comb begin
        if (r_cfg_width == '0) begin
            w_eff = 32'd1;
        end else if (32'(r_cfg_width) > 32'(MAX_WIDTH)) begin
            w_eff = 32'(MAX_WIDTH);
        end else begin
            w_eff = 32'(r_cfg_width);
        end
        if (r_cfg_height == '0) begin
            h_eff = 32'd1;
        end else if (32'(r_cfg_height) > 32'(MAX_HEIGHT)) begin
            h_eff = 32'(MAX_HEIGHT);
        end else begin
            h_eff = 32'(r_cfg_height);
        end
        w_m1 = CW'(w_eff - 32'd1);
        h_m1 = RW'(h_eff - 32'd1);
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign col_last      = (r_j == w_m1);
    assign row_last      = (r_i == h_m1);

    bfe_line_store #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_rd_en   (in_xfer),
        .i_rd_addr (r_col),
        .o_rd_data (rd_data),
        .i_wr_en   (r_state == ST_READ),
        .i_wr_addr (r_j),
        .i_wr_data ({rd_data[PIX_W-1:0], r_pix})
    );

    // Results of one pixel in emission order: bit 0 row above left, bit 1 row above at the
    // row end, bit 2 last row left, bit 3 last row at the row end.
    always_comb begin
        if (r_todo[0]) begin
            k_next = 2'd0;
        end else if (r_todo[1]) begin
            k_next = 2'd1;
        end else if (r_todo[2]) begin
            k_next = 2'd2;
        end else begin
            k_next = 2'd3;
        end
        todo_left = r_todo & ~(4'b0001 << r_k);

        if (k_next[0]) begin
            sel.col_en = {1'b1, (r_j != '0), 1'b0};
        end else begin
            sel.col_en = {1'b1, 1'b1, (r_j > CW'(1))};
        end
        if (k_next[1]) begin
            sel.lane_en = {1'b0, (r_i != '0), 1'b1};
        end else begin
            sel.lane_en = {(r_i > RW'(1)), 1'b1, 1'b1};
        end
    end

    bfe_mean_unit u_mean_unit (
        .i_clk    (i_clk),
        .i_start  (r_state == ST_SUM),
        .i_window (r_window),
        .i_sel    (sel),
        .o_mean   (mean)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                if (((r_i != '0) || row_last) && ((r_j != '0) || col_last)) begin
                    n_state = ST_SUM;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_SUM: n_state = ST_MUL;
            ST_MUL: n_state = ST_LOAD;
            ST_LOAD: begin
                if (out_free) begin
                    n_state = (todo_left == '0) ? ST_IDLE : ST_SUM;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_cfg_width  <= CFG_WIDTH_W'(640);
            r_cfg_height <= CFG_HEIGHT_W'(480);
            r_col        <= '0;
            r_row        <= '0;
            r_window     <= '0;
            r_todo       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_IMAGE_WIDTH:  r_cfg_width  <= i_cfg_data[CFG_WIDTH_W-1:0];
                    REG_IMAGE_HEIGHT: r_cfg_height <= i_cfg_data;
                    default: ;
                endcase
                r_col    <= '0;
                r_row    <= '0;
                r_window <= '0;
            end else if (in_xfer) begin
                if (r_col == w_m1) begin
                    r_col <= '0;
                    r_row <= (r_row == h_m1) ? '0 : r_row + RW'(1);
                end else begin
                    r_col <= r_col + CW'(1);
                end
            end

            if (r_state == ST_READ) begin
                r_window <= {{rd_data, r_pix}, r_window[2], r_window[1]};
                r_todo   <= {row_last && col_last,
                             row_last && (r_j != '0),
                             (r_i != '0) && col_last,
                             (r_i != '0) && (r_j != '0)};
            end else if (r_state == ST_LOAD && out_free) begin
                r_todo <= todo_left;
            end

            if (r_state == ST_LOAD && out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_pix <= s_axis_tdata;
            r_j   <= r_col;
            r_i   <= r_row;
        end
        if (r_state == ST_SUM) begin
            r_k <= k_next;
        end
        if (r_state == ST_LOAD && out_free) begin
            r_out_mean <= mean;
            r_out_row  <= r_k[1] ? ROW_OUT_W'(r_i) : ROW_OUT_W'(r_i - RW'(1));
            r_out_col  <= r_k[0] ? COL_OUT_W'(r_j) : COL_OUT_W'(r_j - CW'(1));
            r_out_last <= (todo_left == '0);
            r_out_eof  <= (r_k == 2'd3);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {OUT_PAD_W'(0), r_out_col, r_out_row, r_out_mean};
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_out_eof;

endmodule

`default_nettype wire

// ----- sv/bfe_line_store.sv -----
// Line store holding the two previous rows, one synchronous memory with registered read.
`default_nettype none

module bfe_line_store
    import bfe_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_WIDTH,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic               i_clk,
    input  wire logic               i_rd_en,
    input  wire logic [AW-1:0]      i_rd_addr,
    output logic      [2*PIX_W-1:0] o_rd_data,   // middle row low byte, upper row high byte
    input  wire logic               i_wr_en,
    input  wire logic [AW-1:0]      i_wr_addr,
    input  wire logic [2*PIX_W-1:0] i_wr_data
);

    logic [2*PIX_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- sv/bfe_mean_unit.sv -----
// Two-stage mean unit: masked neighbourhood sum, then multiply by the count reciprocal.
`default_nettype none

module bfe_mean_unit
    import bfe_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_start,
    input  wire t_window          i_window,
    input  wire t_mean_sel        i_sel,
    output logic      [PIX_W-1:0] o_mean
);

    logic [SUM_W-1:0]         r_sum;
    logic [RECIP_W-1:0]       r_recip;
    logic [SUM_W-1:0]         sum;
    logic [1:0]               ncols;
    logic [1:0]               nlanes;
    logic [SUM_W+RECIP_W-1:0] product;

    always_comb begin
        sum = '0;
        for (int c = 0; c < 3; c++) begin
            for (int l = 0; l < 3; l++) begin
                if (i_sel.col_en[c] && i_sel.lane_en[l]) begin
                    sum = sum + SUM_W'(i_window[c][l*PIX_W +: PIX_W]);
                end
            end
        end
        ncols  = 2'(i_sel.col_en[0]) + 2'(i_sel.col_en[1]) + 2'(i_sel.col_en[2]);
        nlanes = 2'(i_sel.lane_en[0]) + 2'(i_sel.lane_en[1]) + 2'(i_sel.lane_en[2]);
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sum   <= sum;
            r_recip <= f_recip(ncols, nlanes);
        end
    end

    assign product = (SUM_W+RECIP_W)'(r_sum) * (SUM_W+RECIP_W)'(r_recip);

    always_ff @(posedge i_clk) begin
        o_mean <= product[RECIP_SHIFT +: PIX_W];
    end

endmodule

`default_nettype wire

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for the 3x3 box filter: random and directed frames against a predictor.
`timescale 1ns / 100ps

module testbench
    import bfe_pkg::*;
();

    // Margin for the block to return to idle after the last pending result has arrived.
    localparam int SETTLE_CYCLES = 20;
    localparam int QUIET_LIMIT   = 5000;

    typedef struct packed {
        logic [PIX_W-1:0]     smoothed;
        logic [ROW_OUT_W-1:0] row;
        logic [COL_OUT_W-1:0] col;
        logic                 last;
        logic                 eof;
    } t_smoothed;

    class mean_tracker;
        bit [PIX_W-1:0]       upper_row [DEF_MAX_WIDTH];
        bit [PIX_W-1:0]       middle_row [DEF_MAX_WIDTH];
        bit [3*PIX_W-1:0]     win [3];
        int unsigned          row_idx;
        int unsigned          col_idx;
        bit [CFG_WIDTH_W-1:0] width_reg;
        bit [CFG_HEIGHT_W-1:0] height_reg;
        t_smoothed            pending [$];
        int                   errors;

        function new();
            width_reg  = 640;
            height_reg = 480;
            restart();
        endfunction

        function void restart();
            foreach (win[k]) win[k] = '0;
            row_idx = 0;
            col_idx = 0;
        endfunction

        function void write_register(t_cfg_index sel, logic [CFG_DATA_W-1:0] value);
            if (sel == REG_IMAGE_WIDTH) begin
                width_reg = value[CFG_WIDTH_W-1:0];
            end else begin
                height_reg = value[CFG_HEIGHT_W-1:0];
            end
            restart();
        endfunction

        function int unsigned size_clamp(int unsigned v, int unsigned top);
            if (v < 1) return 1;
            if (v > top) return top;
            return v;
        endfunction

        // Mean over the window slots around the centre slot, lanes 0 up to lane_hi.
        function logic [PIX_W-1:0] area_mean(int unsigned centre, int unsigned lane_hi,
                                             bit has_left, bit has_right);
            int unsigned lo, hi, sum, cnt;
            lo  = (has_left && centre >= 1) ? centre - 1 : centre;
            hi  = has_right ? centre + 1 : centre;
            sum = 0;
            cnt = 0;
            if (hi > 2) hi = 2;
            for (int unsigned k = lo; k <= hi; k++) begin
                for (int unsigned l = 0; l <= lane_hi; l++) begin
                    sum += win[k][PIX_W*l +: PIX_W];
                    cnt++;
                end
            end
            return PIX_W'(sum / cnt);
        endfunction

        function void take_pixel(logic [PIX_W-1:0] px);
            int unsigned w, h, i, j, lanes;
            bit [PIX_W-1:0] u, m;
            t_smoothed run [4];
            int n;
            w = size_clamp(width_reg, DEF_MAX_WIDTH);
            h = size_clamp(height_reg, DEF_MAX_HEIGHT);
            i = row_idx;
            j = col_idx;
            n = 0;
            if (j >= w) j = w - 1;
            if (i >= h) i = h - 1;

            u = upper_row[j];
            m = middle_row[j];
            upper_row[j]  = m;
            middle_row[j] = px;
            win[0] = win[1];
            win[1] = win[2];
            win[2] = {u, m, px};

            // Rows above release their results first, then the last row of the frame.
            if (i >= 1) begin
                lanes = (i >= 2) ? 2 : 1;
                if (j >= 1) begin
                    run[n] = '{area_mean(1, lanes, j >= 2, 1'b1), ROW_OUT_W'(i - 1),
                               COL_OUT_W'(j - 1), 1'b0, 1'b0};
                    n++;
                end
                if (j == w - 1) begin
                    run[n] = '{area_mean(2, lanes, j >= 1, 1'b0), ROW_OUT_W'(i - 1),
                               COL_OUT_W'(j), 1'b0, 1'b0};
                    n++;
                end
            end
            if (i == h - 1) begin
                lanes = (i >= 1) ? 1 : 0;
                if (j >= 1) begin
                    run[n] = '{area_mean(1, lanes, j >= 2, 1'b1), ROW_OUT_W'(i),
                               COL_OUT_W'(j - 1), 1'b0, 1'b0};
                    n++;
                end
                if (j == w - 1) begin
                    run[n] = '{area_mean(2, lanes, j >= 1, 1'b0), ROW_OUT_W'(i),
                               COL_OUT_W'(j), 1'b0, 1'b1};
                    n++;
                end
            end
            if (n > 0) run[n-1].last = 1'b1;
            for (int k = 0; k < n; k++) pending.push_back(run[k]);

            j++;
            if (j >= w) begin
                j = 0;
                i++;
                if (i >= h) i = 0;
            end
            row_idx = i;
            col_idx = j;
        endfunction

        function string show(t_smoothed r);
            return $sformatf("%0d at (%0d,%0d) last %0b eof %0b",
                             r.smoothed, r.row, r.col, r.last, r.eof);
        endfunction

        function void complain(string msg);
            errors++;
            if (errors <= 10) $display("%s", msg);
        endfunction

        function void check_output(logic [OUT_TDATA_W-1:0] data, logic last, logic eof);
            t_smoothed got, want;
            got = '{data[PIX_W-1:0], data[PIX_W +: ROW_OUT_W],
                    data[PIX_W+ROW_OUT_W +: COL_OUT_W], last, eof};
            if (pending.size() == 0) begin
                complain($sformatf("unexpected result: %s", show(got)));
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                complain($sformatf("mismatch: expected %s, got %s", show(want), show(got)));
            end
        endfunction
    endclass

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_we      = 1'b0;
    t_cfg_index             i_cfg_index   = REG_IMAGE_WIDTH;
    logic [CFG_DATA_W-1:0]  i_cfg_data    = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [PIX_W-1:0]       s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tlast;
    logic                   m_axis_tuser;

    int unsigned src_idle_pct = 11;
    int unsigned dst_idle_pct = 64;
    int unsigned quiet_cycles = 0;
    mean_tracker board;

    box_filter_3x3_edge_average u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= dst_idle_pct);
        end
    end

    // Results are checked before the pixel of the same edge is predicted, so order is fixed.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                board.check_output(m_axis_tdata, m_axis_tlast, m_axis_tuser);
            end
            if (s_axis_tvalid && s_axis_tready) begin
                board.take_pixel(s_axis_tdata);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_pixel(input logic [PIX_W-1:0] px);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= px;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Holds the stream off until every pending result has arrived and the block has settled.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (board.pending.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_index sel, input logic [CFG_DATA_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= sel;
        i_cfg_data  <= value;
        @(negedge i_clk);
        board.write_register(sel, value);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    initial begin
        logic [PIX_W-1:0] directed_px [$];
        logic [PIX_W-1:0] px;
        logic [CFG_DATA_W-1:0] wval, hval;
        int unsigned pick, sent;
        board = new();
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Three by three frame: corners, edges and the centre, then one pixel into the next frame.
        write_reg(REG_IMAGE_WIDTH, 13'd3);
        write_reg(REG_IMAGE_HEIGHT, 13'd3);
        directed_px = '{8'd255, 8'd255, 8'd0, 8'd255, 8'd255, 8'd255, 8'd0, 8'd255, 8'd1,
                        8'd170};
        foreach (directed_px[k]) send_pixel(directed_px[k]);
        drain();

        // A width of zero counts as one: a single column two rows high.
        write_reg(REG_IMAGE_WIDTH, 13'd0);
        write_reg(REG_IMAGE_HEIGHT, 13'd2);
        directed_px = '{8'd7, 8'd200, 8'd0, 8'd255};
        foreach (directed_px[k]) send_pixel(directed_px[k]);
        drain();

        // Oversized width clamps to the maximum, zero height to one row; frame cut short.
        write_reg(REG_IMAGE_WIDTH, 13'h1FFF);
        write_reg(REG_IMAGE_HEIGHT, 13'd0);
        directed_px = '{8'd255, 8'd255, 8'd255, 8'd0, 8'd128};
        foreach (directed_px[k]) send_pixel(directed_px[k]);
        drain();

        // One pixel per row with the height clamped to its maximum.
        write_reg(REG_IMAGE_WIDTH, 13'd1);
        write_reg(REG_IMAGE_HEIGHT, 13'h1FFF);
        directed_px = '{8'd255, 8'd0, 8'd255, 8'd85, 8'd255};
        foreach (directed_px[k]) send_pixel(directed_px[k]);

        for (int ph = 0; ph < 3; ph++) begin
            src_idle_pct = (ph == 0) ? 11 : (ph == 1) ? 64 : 0;
            dst_idle_pct = (ph == 0) ? 64 : (ph == 1) ? 11 : 0;
            sent = 0;
            while (sent < 28) begin
                pick = $urandom_range(3);
                wval = ($urandom_range(9) == 0) ? CFG_DATA_W'($urandom_range(8191))
                                                : CFG_DATA_W'($urandom_range(7));
                hval = ($urandom_range(9) == 0) ? CFG_DATA_W'($urandom_range(8191))
                                                : CFG_DATA_W'($urandom_range(5));
                if (pick == 1) begin
                    drain();
                    if ($urandom_range(1)) begin
                        write_reg(REG_IMAGE_WIDTH, wval);
                    end else begin
                        write_reg(REG_IMAGE_HEIGHT, hval);
                    end
                end else if (pick >= 2) begin
                    drain();
                    write_reg(REG_IMAGE_WIDTH, wval);
                    write_reg(REG_IMAGE_HEIGHT, hval);
                end else if ($urandom_range(1)) begin
                    drain();
                end
                repeat ($urandom_range(6, 16)) begin
                    if ($urandom_range(7) == 0) begin
                        px = $urandom_range(1) ? 8'hFF : 8'h00;
                    end else begin
                        px = PIX_W'($urandom_range(255));
                    end
                    send_pixel(px);
                    sent++;
                end
            end
        end

        drain();
        if (board.errors == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
